>>> rtl/core/particle_euler_step_with_trail_assert.svh
// Assertion macros for the particle Euler step block.
`ifndef PARTICLE_EULER_STEP_WITH_TRAIL_ASSERT_SVH
`define PARTICLE_EULER_STEP_WITH_TRAIL_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every edge outside reset
`define PESW_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Condition that must hold in the cycle after the trigger
`define PESW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PESW_ASSERT(label, clk, rst, expr, msg)
`define PESW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/pesw_pkg.sv
// Shared types, constants and helpers for the particle Euler step block.
`timescale 1ns / 1ps
package pesw_pkg;

  // Trail ring geometry (depth is a power of two)
  localparam int TRAIL_DEPTH = 256;
  localparam int TRAIL_AW    = $clog2(TRAIL_DEPTH);
  localparam int FILL_W      = TRAIL_AW + 1;
  localparam int TRAIL_W     = 64;

  // Configuration port address width (five 32-bit registers)
  localparam int PADDR_W = 5;

  typedef logic signed [31:0] q16_t;
  typedef logic [TRAIL_AW-1:0] slot_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef enum logic [2:0] {
    OP_ACCEL    = 3'd0,
    OP_ADVANCE  = 3'd1,
    OP_BOUNCE   = 3'd2,
    OP_READ     = 3'd3,
    OP_SET_POS  = 3'd4,
    OP_SET_VEL  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_BOTTOM = 3'd1,
    REG_TOP    = 3'd2,
    REG_LEFT   = 3'd3,
    REG_RIGHT  = 3'd4
  } reg_idx_t;

  // -0.9 in Q0.16, as a multiplier operand
  localparam logic signed [20:0] REFLECT_NEG = -21'sd58982;
  // 5.0 in Q16.16: a larger axis distance is far on its own
  localparam logic [31:0] NEAR_LIMIT = 32'd327680;
  // 25.0 in Q32.32
  localparam logic [38:0] DIST_SQ_LIMIT = 39'd25 << 32;

  // Clamp a wide signed sum to 32 bits
  function automatic q16_t sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

>>> rtl/core/pesw_ifs.sv
// Request and result channel interfaces for the particle Euler step block.
`timescale 1ns / 1ps
interface pesw_req_if;
  import pesw_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  q16_t        value_x;
  q16_t        value_y;
  logic [15:0] time_step;
  logic [7:0]  trail_index;

  modport source (output valid, opcode, value_x, value_y, time_step, trail_index,
                  input ready);
  modport sink   (input valid, opcode, value_x, value_y, time_step, trail_index,
                  output ready);
endinterface

interface pesw_rsp_if;
  import pesw_pkg::*;
  logic       valid;
  logic       ready;
  q16_t       pos_x;
  q16_t       pos_y;
  q16_t       vel_x;
  q16_t       vel_y;
  logic [8:0] trail_count;
  logic       trail_added;
  logic [1:0] bounced;
  q16_t       trail_x;
  q16_t       trail_y;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, trail_count, trail_added,
                  bounced, trail_x, trail_y, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, trail_count, trail_added,
                  bounced, trail_x, trail_y, output ready);
endinterface

>>> rtl/core/particle_euler_step_with_trail.sv
// Euler integrator for one 2-D body in Q16.16 with a ring of recorded positions.
// A request holds the engine until its result is registered: set and unused opcodes pass
//   the fewest states, then read trail, then accelerate and bounce; advance passes the most,
//   above all when the distance check needs both squares, and the result waits until the
//   last one is taken. One shared 33x21 multiplier and registered trail read set the steps.
// Synchronous active-high reset zeroes position, velocity and trail, and loads the defaults.
`timescale 1ns / 1ps
`include "particle_euler_step_with_trail_assert.svh"
module particle_euler_step_with_trail (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pesw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  pesw_req_if.sink                     req,
  pesw_rsp_if.source                   rsp
);
  import pesw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MX, S_MY, S_AY, S_DIST, S_SQX, S_SQY,
    S_BY, S_BX, S_BV, S_RD0, S_RD1, S_EXEC, S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic [26:0]        body_radius;
  logic signed [15:0] bound_bottom;
  logic signed [15:0] bound_top;
  logic signed [15:0] bound_left;
  logic signed [15:0] bound_right;

  // Body state and trail ring pointers
  q16_t  pos_x, pos_y, vel_x, vel_y;
  slot_t head;
  fill_t fill;

  // Latched request
  logic [2:0]  op_r;
  q16_t        vx_r, vy_r;
  logic [15:0] dt_r;
  logic [7:0]  idx_r;

  // Per-request results
  logic        added_r;
  logic [1:0]  hit_r;
  q16_t        trl_x, trl_y;
  logic [37:0] sq_x;

  // Result register
  logic       out_valid;
  q16_t       out_pos_x, out_pos_y, out_vel_x, out_vel_y;
  logic [8:0] out_count;
  logic       out_added;
  logic [1:0] out_hit;
  q16_t       out_trl_x, out_trl_y;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_p;

  // Trail memory
  logic               ram_we;
  slot_t              wr_addr, rd_addr;
  logic [TRAIL_W-1:0] rd_data;

  logic accel;
  assign accel = (op_r == OP_ACCEL);

  // APB: always ready, reads return the register value
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_RADIUS: prdata = {5'b0, body_radius};
      REG_BOTTOM: prdata = {{16{bound_bottom[15]}}, bound_bottom};
      REG_TOP:    prdata = {{16{bound_top[15]}}, bound_top};
      REG_LEFT:   prdata = {{16{bound_left[15]}}, bound_left};
      REG_RIGHT:  prdata = {{16{bound_right[15]}}, bound_right};
      default:    prdata = 32'h0;
    endcase
  end

  // Scaled add: target + floor(rate*dt / 2^16), saturated
  q16_t               sc_base, sc_delta, sc_sum;
  logic signed [33:0] sc_wide;
  always_comb begin
    if (state == S_MY) begin
      sc_base = accel ? vel_x : pos_x;
    end else begin
      sc_base = accel ? vel_y : pos_y;
    end
  end
  assign sc_delta = mul_p[47:16];
  assign sc_wide  = 34'(sc_base) + 34'(sc_delta);
  assign sc_sum   = sat32(sc_wide);

  // Reflection: floor((-v*0.9q + 0.5) / 2^16)
  logic signed [53:0] refl_sum;
  q16_t               refl_v;
  assign refl_sum = mul_p + 54'sd32768;
  assign refl_v   = refl_sum[47:16];

  // Distance from the newest trail point
  q16_t               last_x, last_y;
  logic signed [32:0] dx, dy;
  logic [31:0]        abs_dx, abs_dy;
  logic               far_coarse;
  logic [38:0]        sq_sum;
  assign last_x     = rd_data[63:32];
  assign last_y     = rd_data[31:0];
  assign dx         = 33'(last_x) - 33'(pos_x);
  assign dy         = 33'(last_y) - 33'(pos_y);
  assign abs_dx     = dx[32] ? 32'(-dx) : dx[31:0];
  assign abs_dy     = dy[32] ? 32'(-dy) : dy[31:0];
  assign far_coarse = (abs_dx > NEAR_LIMIT) || (abs_dy > NEAR_LIMIT);
  assign sq_sum     = 39'(sq_x) + 39'(mul_p[37:0]);

  // Wall limits for the axis in hand (y first, then x)
  logic signed [15:0] wall_lo, wall_hi;
  q16_t               wall_lo_q, wall_hi_q, bpos, b_new;
  logic signed [33:0] rad34, lim_lo, lim_hi, bpos34;
  logic               b_below, b_above, b_hit;
  assign wall_lo   = (state == S_BY) ? bound_bottom : bound_left;
  assign wall_hi   = (state == S_BY) ? bound_top : bound_right;
  assign bpos      = (state == S_BY) ? pos_y : pos_x;
  assign wall_lo_q = {wall_lo, 16'h0000};
  assign wall_hi_q = {wall_hi, 16'h0000};
  assign rad34     = {7'b0, body_radius};
  assign lim_lo    = 34'(wall_lo_q) + rad34;
  assign lim_hi    = 34'(wall_hi_q) - rad34;
  assign bpos34    = 34'(bpos);
  assign b_below   = bpos34 < lim_lo;
  assign b_above   = bpos34 > lim_hi;
  assign b_hit     = b_below || b_above;
  assign b_new     = sat32(b_below ? lim_lo : lim_hi);

  // Multiplier operand selection
  always_comb begin
    case (state)
      S_MX: begin
        mul_a = 33'(accel ? vx_r : vel_x);
        mul_b = {5'b0, dt_r};
      end
      S_MY: begin
        mul_a = 33'(accel ? vy_r : vel_y);
        mul_b = {5'b0, dt_r};
      end
      S_DIST: begin
        mul_a = {1'b0, abs_dx};
        mul_b = {1'b0, abs_dx[19:0]};
      end
      S_SQX: begin
        mul_a = {1'b0, abs_dy};
        mul_b = {1'b0, abs_dy[19:0]};
      end
      S_BY: begin
        mul_a = 33'(vel_y);
        mul_b = REFLECT_NEG;
      end
      S_BX: begin
        mul_a = 33'(vel_x);
        mul_b = REFLECT_NEG;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Trail memory: new points go after the newest; when full that is the oldest slot
  logic record;
  assign record  = ((state == S_DIST) && ((fill == '0) || far_coarse)) ||
                   ((state == S_SQY) && (sq_sum > DIST_SQ_LIMIT));
  assign ram_we  = record;
  assign wr_addr = head + fill[TRAIL_AW-1:0];
  assign rd_addr = (state == S_RD0) ? head + TRAIL_AW'(idx_r)
                                    : head + fill[TRAIL_AW-1:0] - slot_t'(1);

  pesw_ram #(
    .WIDTH (TRAIL_W),
    .DEPTH (TRAIL_DEPTH)
  ) u_trail (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata ({pos_x, pos_y}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign req.ready = (state == S_IDLE);

  // Sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      pos_x        <= '0;
      pos_y        <= '0;
      vel_x        <= '0;
      vel_y        <= '0;
      head         <= '0;
      fill         <= '0;
      body_radius  <= 27'd655360;
      bound_bottom <= 16'sd0;
      bound_top    <= 16'sd600;
      bound_left   <= 16'sd0;
      bound_right  <= 16'sd800;
    end else begin
      // configuration writes
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          REG_RADIUS: body_radius  <= pwdata[26:0];
          REG_BOTTOM: bound_bottom <= pwdata[15:0];
          REG_TOP:    bound_top    <= pwdata[15:0];
          REG_LEFT:   bound_left   <= pwdata[15:0];
          REG_RIGHT:  bound_right  <= pwdata[15:0];
          default: ;
        endcase
      end

      // result taken; the final state reloads the register itself
      if (rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      // trail append
      if (record) begin
        added_r <= 1'b1;
        if (fill == fill_t'(TRAIL_DEPTH)) begin
          head <= head + slot_t'(1);
        end else begin
          fill <= fill + fill_t'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r    <= req.opcode;
            vx_r    <= req.value_x;
            vy_r    <= req.value_y;
            dt_r    <= req.time_step;
            idx_r   <= req.trail_index;
            added_r <= 1'b0;
            hit_r   <= 2'b00;
            trl_x   <= '0;
            trl_y   <= '0;
            case (req.opcode)
              OP_ACCEL, OP_ADVANCE: state <= S_MX;
              OP_BOUNCE:            state <= S_BY;
              OP_READ:              state <= S_RD0;
              default:              state <= S_EXEC;
            endcase
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          if (accel) begin
            vel_x <= sc_sum;
          end else begin
            pos_x <= sc_sum;
          end
          state <= S_AY;
        end
        S_AY: begin
          if (accel) begin
            vel_y <= sc_sum;
            state <= S_FIN;
          end else begin
            pos_y <= sc_sum;
            state <= S_DIST;
          end
        end
        S_DIST: state <= record ? S_FIN : S_SQX;
        S_SQX: begin
          sq_x  <= mul_p[37:0];
          state <= S_SQY;
        end
        S_SQY: state <= S_FIN;
        S_BY: begin
          if (b_hit) begin
            pos_y    <= b_new;
            hit_r[1] <= 1'b1;
          end
          state <= S_BX;
        end
        S_BX: begin
          if (hit_r[1]) begin
            vel_y <= refl_v;
          end
          if (b_hit) begin
            pos_x    <= b_new;
            hit_r[0] <= 1'b1;
          end
          state <= S_BV;
        end
        S_BV: begin
          if (hit_r[0]) begin
            vel_x <= refl_v;
          end
          state <= S_FIN;
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          if (32'(idx_r) < 32'(fill)) begin
            trl_x <= last_x;
            trl_y <= last_y;
          end
          state <= S_FIN;
        end
        S_EXEC: begin
          case (op_r)
            OP_SET_POS: begin
              pos_x <= vx_r;
              pos_y <= vy_r;
              head  <= '0;
              fill  <= '0;
            end
            OP_SET_VEL: begin
              vel_x <= vx_r;
              vel_y <= vy_r;
            end
            default: ;
          endcase
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_pos_x <= pos_x;
            out_pos_y <= pos_y;
            out_vel_x <= vel_x;
            out_vel_y <= vel_y;
            out_count <= 9'(fill);
            out_added <= added_r;
            out_hit   <= hit_r;
            out_trl_x <= trl_x;
            out_trl_y <= trl_y;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pos_x       = out_pos_x;
  assign rsp.pos_y       = out_pos_y;
  assign rsp.vel_x       = out_vel_x;
  assign rsp.vel_y       = out_vel_y;
  assign rsp.trail_count = out_count;
  assign rsp.trail_added = out_added;
  assign rsp.bounced     = out_hit;
  assign rsp.trail_x     = out_trl_x;
  assign rsp.trail_y     = out_trl_y;

  // Checks
  `PESW_ASSERT(a_fill_bound, clk, rst, fill <= fill_t'(TRAIL_DEPTH), "trail fill beyond depth")
  `PESW_ASSERT(a_we_in_check, clk, rst, !ram_we || state == S_DIST || state == S_SQY, "stray trail write")
  `PESW_ASSERT_NEXT(a_busy_after_req, clk, rst, req.valid && req.ready, state != S_IDLE, "request not taken up")
  `PESW_ASSERT_NEXT(a_set_pos_clears, clk, rst, state == S_EXEC && op_r == OP_SET_POS, fill == '0 && head == '0, "trail not cleared")
  `PESW_ASSERT(a_added_nonempty, clk, rst, !(out_valid && out_added) || out_count != '0, "point added to empty trail")

endmodule

>>> rtl/core/pesw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pesw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> bench/tb_particle_euler_step_with_trail.sv
// Self-checking testbench for the particle Euler step block with its position trail.
`timescale 1ns / 1ps
module tb_particle_euler_step_with_trail;
  import pesw_pkg::q16_t;
  import pesw_pkg::TRAIL_DEPTH;
  import pesw_pkg::PADDR_W;
  import pesw_pkg::OP_ACCEL;
  import pesw_pkg::OP_ADVANCE;
  import pesw_pkg::OP_BOUNCE;
  import pesw_pkg::OP_READ;
  import pesw_pkg::OP_SET_POS;
  import pesw_pkg::OP_SET_VEL;
  import pesw_pkg::reg_idx_t;
  import pesw_pkg::REG_RADIUS;
  import pesw_pkg::REG_BOTTOM;
  import pesw_pkg::REG_TOP;
  import pesw_pkg::REG_LEFT;
  import pesw_pkg::REG_RIGHT;

  // Opcodes with no operation behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam q16_t Q_MAX = 32'sh7fffffff;
  localparam q16_t Q_MIN = 32'sh80000000;
  localparam q16_t Q_UNIT = 32'sd65536;
  // 0.9 in Q0.16 and 25.0 in Q32.32
  localparam longint REFLECT_GAIN = 58982;
  localparam logic [63:0] RECORD_GAP_SQ = 64'd25 << 32;
  localparam int MAX_WAIT = 17;
  localparam int SETTLE_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 330;

  typedef struct packed {
    logic [2:0]  op;
    q16_t        vx;
    q16_t        vy;
    logic [15:0] dt;
    logic [7:0]  idx;
  } body_cmd_t;

  typedef struct packed {
    q16_t       pos_x;
    q16_t       pos_y;
    q16_t       vel_x;
    q16_t       vel_y;
    logic [8:0] count;
    logic       added;
    logic [1:0] bounced;
    q16_t       trail_x;
    q16_t       trail_y;
  } body_state_t;

  typedef struct {
    body_cmd_t   cmd;
    bit          typed;
    body_state_t want;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  pesw_req_if req_ch ();
  pesw_rsp_if rsp_ch ();

  particle_euler_step_with_trail DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Predictor state: body, trail ring and register copies
  q16_t body_x, body_y, speed_x, speed_y;
  q16_t ring_x [TRAIL_DEPTH];
  q16_t ring_y [TRAIL_DEPTH];
  int unsigned ring_head, ring_fill;
  logic [26:0] cfg_radius;
  logic signed [15:0] cfg_bottom, cfg_top, cfg_left, cfg_right;

  body_state_t pending_results [$];
  directed_row_t directed_rows [$];
  bit failed = 1'b0;
  bit calm = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic q16_t clip32(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q16_t'(v);
  endfunction

  // base + rate*dt, product floored to Q16.16
  function automatic q16_t scaled_add(input q16_t base, input q16_t rate, input logic [15:0] dt);
    longint prod;
    prod = longint'(rate) * longint'({16'd0, dt});
    return clip32(longint'(base) + (prod >>> 16));
  endfunction

  function automatic q16_t reflect(input q16_t v);
    longint prod;
    prod = -longint'(v) * REFLECT_GAIN + 32768;
    return q16_t'(prod >>> 16);
  endfunction

  // Newest trail point further than 5.0 from the body
  function automatic bit far_from_newest();
    int unsigned last;
    longint dx, dy;
    logic [63:0] ax, ay, sx, sy;
    last = (ring_head + ring_fill - 1) % TRAIL_DEPTH;
    dx = longint'(ring_x[last]) - longint'(body_x);
    dy = longint'(ring_y[last]) - longint'(body_y);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sx = ax * ax;
    sy = ay * ay;
    if (sx > RECORD_GAP_SQ || sy > RECORD_GAP_SQ) return 1'b1;
    return (sx + sy) > RECORD_GAP_SQ;
  endfunction

  // Clamp one axis to the inset box; crossed limits: upper wins unless p < lo
  function automatic bit clamp_axis(inout q16_t p, inout q16_t v,
                                    input logic signed [15:0] low_wall,
                                    input logic signed [15:0] high_wall);
    longint lo, hi;
    lo = longint'(low_wall) * 65536 + longint'(cfg_radius);
    hi = longint'(high_wall) * 65536 - longint'(cfg_radius);
    if (longint'(p) < lo || longint'(p) > hi) begin
      p = clip32((longint'(p) < lo) ? lo : hi);
      v = reflect(v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void reset_predictor();
    body_x = '0;
    body_y = '0;
    speed_x = '0;
    speed_y = '0;
    ring_head = 0;
    ring_fill = 0;
    cfg_radius = 27'd655360;
    cfg_bottom = 16'sd0;
    cfg_top = 16'sd600;
    cfg_left = 16'sd0;
    cfg_right = 16'sd800;
  endfunction

  // Expected result of one request; advances the predictor state
  function automatic body_state_t euler_predict(input body_cmd_t c);
    body_state_t s;
    int unsigned slot;
    s = '0;
    case (c.op)
      OP_ACCEL: begin
        speed_x = scaled_add(speed_x, c.vx, c.dt);
        speed_y = scaled_add(speed_y, c.vy, c.dt);
      end
      OP_ADVANCE: begin
        body_x = scaled_add(body_x, speed_x, c.dt);
        body_y = scaled_add(body_y, speed_y, c.dt);
        if (ring_fill == 0 || far_from_newest()) begin
          if (ring_fill < TRAIL_DEPTH) begin
            slot = (ring_head + ring_fill) % TRAIL_DEPTH;
            ring_fill++;
          end else begin
            // ring full: overwrite the oldest point
            slot = ring_head;
            ring_head = (ring_head + 1) % TRAIL_DEPTH;
          end
          ring_x[slot] = body_x;
          ring_y[slot] = body_y;
          s.added = 1'b1;
        end
      end
      OP_BOUNCE: begin
        s.bounced[1] = clamp_axis(body_y, speed_y, cfg_bottom, cfg_top);
        s.bounced[0] = clamp_axis(body_x, speed_x, cfg_left, cfg_right);
      end
      OP_READ: begin
        if (c.idx < ring_fill) begin
          slot = (ring_head + c.idx) % TRAIL_DEPTH;
          s.trail_x = ring_x[slot];
          s.trail_y = ring_y[slot];
        end
      end
      OP_SET_POS: begin
        body_x = c.vx;
        body_y = c.vy;
        ring_head = 0;
        ring_fill = 0;
      end
      OP_SET_VEL: begin
        speed_x = c.vx;
        speed_y = c.vy;
      end
      default: begin
      end
    endcase
    s.pos_x = body_x;
    s.pos_y = body_y;
    s.vel_x = speed_x;
    s.vel_y = speed_y;
    s.count = 9'(ring_fill);
    return s;
  endfunction

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic q16_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return q16_t'(int'($urandom_range(0, 262144000)) - 131072000);
      5: return q16_t'(int'($urandom_range(0, 65536000)) - 32768000);
      6, 7: return q16_t'($urandom);
      8: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      default: return q16_t'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Random request, weighted towards advance so the trail fills and wraps
  function automatic body_cmd_t make_random_cmd();
    body_cmd_t c;
    int unsigned w;
    w = $urandom_range(0, 999);
    c.vx = pick_value();
    c.vy = pick_value();
    case ($urandom_range(0, 9))
      0: c.dt = 16'd0;
      1: c.dt = 16'hffff;
      default: c.dt = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      c.idx = 8'($urandom_range(0, 255));
    end else begin
      c.idx = 8'((ring_fill > 255) ? $urandom_range(0, 255) : $urandom_range(0, ring_fill));
    end
    if (w < 130) begin
      c.op = OP_ACCEL;
    end else if (w < 520) begin
      c.op = OP_ADVANCE;
    end else if (w < 650) begin
      c.op = OP_BOUNCE;
    end else if (w < 810) begin
      c.op = OP_READ;
    end else if (w < 813) begin
      c.op = OP_SET_POS;
    end else if (w < 930) begin
      c.op = OP_SET_VEL;
    end else if (w < 960) begin
      c.op = w[0] ? OP_SPARE_HI : OP_SPARE_LO;
    end else begin
      // standing still: the body does not move
      c.op = OP_ADVANCE;
      c.dt = 16'd0;
    end
    return c;
  endfunction

  function automatic body_state_t state_view(input q16_t px, input q16_t py,
                                             input q16_t vx, input q16_t vy);
    body_state_t s;
    s = '0;
    s.pos_x = px;
    s.pos_y = py;
    s.vel_x = vx;
    s.vel_y = vy;
    return s;
  endfunction

  task automatic add_row(input logic [2:0] op, input q16_t vx, input q16_t vy,
                         input logic [15:0] dt, input logic [7:0] idx,
                         input bit typed, input body_state_t want);
    directed_row_t row;
    row.cmd = '{op: op, vx: vx, vy: vy, dt: dt, idx: idx};
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // APB write: setup, access, then idle before returning
  task automatic write_reg(input reg_idx_t which, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (which)
      REG_RADIUS: cfg_radius = data[26:0];
      REG_BOTTOM: cfg_bottom = data[15:0];
      REG_TOP:    cfg_top = data[15:0];
      REG_LEFT:   cfg_left = data[15:0];
      REG_RIGHT:  cfg_right = data[15:0];
      default: begin
      end
    endcase
  endtask

  // Drive one request and record its expected result on acceptance
  task automatic send_cmd(input body_cmd_t c, input int gap, input bit typed,
                          input body_state_t want);
    body_state_t seen;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= c.op;
    req_ch.value_x <= c.vx;
    req_ch.value_y <= c.vy;
    req_ch.time_step <= c.dt;
    req_ch.trail_index <= c.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    seen = euler_predict(c);
    pending_results.insert(pending_results.size(), typed ? want : seen);
  endtask

  // Drop valid and wait, with a limit, for every outstanding result
  task automatic wait_settled();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && guard < 4000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      failed = 1'b1;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] wall_word(input logic signed [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  task automatic configure(input int phase);
    logic [26:0] radius;
    logic signed [15:0] bot, top, lft, rgt;
    case (phase)
      1: begin
        // widest box, no inset
        radius = 27'd0;
        bot = 16'sh8000;
        top = 16'sd32767;
        lft = 16'sh8000;
        rgt = 16'sd32767;
      end
      2: begin
        // crossed limits at the extremes: every bounce hits and saturates
        radius = 27'd67108864;
        bot = 16'sd32767;
        top = 16'sh8000;
        lft = 16'sd32767;
        rgt = 16'sh8000;
      end
      3: begin
        radius = 27'($urandom_range(0, 50 * 65536));
        bot = -16'($urandom_range(0, 1500));
        top = 16'($urandom_range(0, 1500));
        lft = -16'($urandom_range(0, 1500));
        rgt = 16'($urandom_range(0, 1500));
      end
      4: begin
        radius = 27'($urandom_range(0, 67108864));
        bot = 16'($urandom_range(0, 65535));
        top = 16'($urandom_range(0, 65535));
        lft = 16'($urandom_range(0, 65535));
        rgt = 16'($urandom_range(0, 65535));
      end
      default: begin
        radius = 27'd655360;
        bot = 16'sd0;
        top = 16'sd600;
        lft = 16'sd0;
        rgt = 16'sd800;
      end
    endcase
    write_reg(REG_RADIUS, {5'd0, radius});
    write_reg(REG_BOTTOM, wall_word(bot));
    write_reg(REG_TOP, wall_word(top));
    write_reg(REG_LEFT, wall_word(lft));
    write_reg(REG_RIGHT, wall_word(rgt));
  endtask

  task automatic run_random(input int count);
    body_cmd_t c;
    for (int n = 0; n < count; n++) begin
      // stretches with no idling on either side
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      // hold off once per phase until the block has drained
      if (n == count / 2) wait_settled();
      c = make_random_cmd();
      send_cmd(c, pick_gap(), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Result side: random stalls, compare against the oldest expectation
  initial begin
    body_state_t got, want;
    int stall;
    @(negedge rst);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got = '{pos_x: rsp_ch.pos_x, pos_y: rsp_ch.pos_y, vel_x: rsp_ch.vel_x,
              vel_y: rsp_ch.vel_y, count: rsp_ch.trail_count, added: rsp_ch.trail_added,
              bounced: rsp_ch.bounced, trail_x: rsp_ch.trail_x, trail_y: rsp_ch.trail_y};
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("vel_x", want.vel_x, got.vel_x);
        check_field("vel_y", want.vel_y, got.vel_y);
        check_field("trail_count", want.count, got.count);
        check_field("trail_added", want.added, got.added);
        check_field("bounced", want.bounced, got.bounced);
        check_field("trail_x", want.trail_x, got.trail_x);
        check_field("trail_y", want.trail_y, got.trail_y);
      end
    end
  end

  // Stimulus
  initial begin
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_ACCEL;
    req_ch.value_x <= '0;
    req_ch.value_y <= '0;
    req_ch.time_step <= '0;
    req_ch.trail_index <= '0;
    rsp_ch.ready <= 1'b0;
    reset_predictor();

    // Directed table, default registers
    add_row(OP_READ, 0, 0, 16'd0, 8'd0, 1'b1, state_view(0, 0, 0, 0));
    add_row(OP_SPARE_LO, Q_MAX, Q_MIN, 16'hffff, 8'd255, 1'b1, state_view(0, 0, 0, 0));
    add_row(OP_SET_VEL, Q_MAX, Q_MIN, 16'd0, 8'd0, 1'b1, state_view(0, 0, Q_MAX, Q_MIN));
    // saturating acceleration
    add_row(OP_ACCEL, Q_MAX, Q_MIN, 16'hffff, 8'd0, 1'b1, state_view(0, 0, Q_MAX, Q_MIN));
    add_row(OP_ADVANCE, 0, 0, 16'hffff, 8'd0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 16'hffff, 8'd0, 1'b0, '0);
    add_row(OP_SPARE_HI, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_BOUNCE, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_READ, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_READ, 0, 0, 16'd0, 8'd1, 1'b0, '0);
    add_row(OP_READ, 0, 0, 16'd0, 8'd255, 1'b0, '0);
    add_row(OP_SET_POS, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    // trail gap of exactly 5.0 is not recorded, a hair more is
    add_row(OP_SET_VEL, 10 * Q_UNIT, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 16'd32768, 8'd0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 16'd32768, 8'd0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 16'd32769, 8'd0, 1'b0, '0);
    add_row(OP_SET_VEL, -3 * Q_UNIT, 4 * Q_UNIT, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_ADVANCE, 0, 0, 16'hffff, 8'd0, 1'b0, '0);
    // products round toward minus infinity
    add_row(OP_ACCEL, -Q_UNIT, 1, 16'd1, 8'd0, 1'b0, '0);
    add_row(OP_READ, 0, 0, 16'd0, 8'd1, 1'b0, '0);
    // outside left and above top
    add_row(OP_SET_POS, -5 * Q_UNIT, 700 * Q_UNIT, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_BOUNCE, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_BOUNCE, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_READ, 0, 0, 16'd0, 8'd0, 1'b0, '0);
    add_row(OP_SET_VEL, 0, 0, 16'd0, 8'd0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, pick_gap(), directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase <= 5; phase++) begin
      wait_settled();
      if (phase > 0) configure(phase);
      run_random(ITEMS_PER_PHASE);
    end

    wait_settled();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
